FILE: rtl/tlvf_pkg.sv
package tlvf_pkg;

   // Largest buffer the parser accepts; longer remaining counts are clamped to it
   localparam logic [32:0] MaxBufferBytes = 33'd65536;

   // Highest legal code and size byte
   localparam logic [7:0] CodeLimit = 8'd127;

   // Saturation point of the running total
   localparam logic [16:0] TotalMax = 17'h1FFFF;

   // Packed port widths
   localparam int ReqDataWidth = 32;
   localparam int RspDataWidth = 32;

   typedef enum logic [2:0] {
      StOk            = 3'd0,
      StBadCode       = 3'd1,
      StEndAfterCode  = 3'd2,
      StBadSize       = 3'd3,
      StTruncated     = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [16:0] bytes_left;
   } item_type;

   typedef struct packed {
      logic        value_valid;
      logic [7:0]  value_byte;
      logic        done_res;
      status_type  status;
      logic [16:0] total_size;
   } result_type;

endpackage

FILE: rtl/tlvf_parse_core.sv
module tlvf_parse_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  tlvf_pkg::item_type   item,
   input  logic [6:0]           code_of_interest,
   output tlvf_pkg::result_type result
);

   typedef enum logic [1:0] {
      PhCode  = 2'd0,
      PhSize  = 2'd1,
      PhValue = 2'd2
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [6:0]           value_remaining_ff, value_remaining_in;
   logic                 record_matches_ff, record_matches_in;
   logic [16:0]          matched_total_ff, matched_total_in;
   tlvf_pkg::status_type error_status_ff, error_status_in;
   logic [6:0]           pending_code_ff, pending_code_in;

   logic [32:0] left_wide;
   logic [32:0] left_c;
   logic        final_byte;
   logic [7:0]  b;
   logic [17:0] total_sum;
   logic [6:0]  rem_dec;
   logic        size_too_long;

   // Clamp the remaining count and spot the final byte
   always_comb begin
      b          = item.data_byte;
      left_wide  = {16'b0, item.bytes_left};
      left_c     = (left_wide > tlvf_pkg::MaxBufferBytes) ? tlvf_pkg::MaxBufferBytes
                                                          : left_wide;
      final_byte = (left_c <= 33'd1);
      // a zero count is excluded from the size check and never flags truncation
      size_too_long = (left_c != 33'd0) && ({25'b0, b} >= left_c);
      total_sum  = {1'b0, matched_total_ff} + {10'b0, b};
      rem_dec    = (value_remaining_ff != 7'd0) ? (value_remaining_ff - 7'd1)
                                                : 7'd0;
   end

   // Parse one byte: next state and the request's result
   always_comb begin
      phase_in           = phase_ff;
      value_remaining_in = value_remaining_ff;
      record_matches_in  = record_matches_ff;
      matched_total_in   = matched_total_ff;
      error_status_in    = error_status_ff;
      pending_code_in    = pending_code_ff;
      result.value_valid = 1'b0;
      result.value_byte  = 8'd0;

      if (error_status_ff == tlvf_pkg::StOk) begin
         unique case (phase_ff)
            PhCode: begin
               if (b > tlvf_pkg::CodeLimit) begin
                  error_status_in = tlvf_pkg::StBadCode;
               end else if (final_byte) begin
                  error_status_in = tlvf_pkg::StEndAfterCode;
               end else begin
                  pending_code_in = b[6:0];
                  phase_in        = PhSize;
               end
            end
            PhSize: begin
               if (b > tlvf_pkg::CodeLimit) begin
                  error_status_in = tlvf_pkg::StBadSize;
               end else if (size_too_long) begin
                  error_status_in = tlvf_pkg::StTruncated;
               end else begin
                  record_matches_in = (pending_code_ff == code_of_interest);
                  if (pending_code_ff == code_of_interest) begin
                     matched_total_in = total_sum[17] ? tlvf_pkg::TotalMax
                                                      : total_sum[16:0];
                  end
                  value_remaining_in = b[6:0];
                  phase_in           = (b == 8'd0) ? PhCode : PhValue;
               end
            end
            PhValue: begin
               if (record_matches_ff) begin
                  result.value_valid = 1'b1;
                  result.value_byte  = b;
               end
               value_remaining_in = rem_dec;
               if (rem_dec == 7'd0) begin
                  phase_in          = PhCode;
                  record_matches_in = 1'b0;
               end else if (final_byte) begin
                  error_status_in = tlvf_pkg::StTruncated;
               end
            end
            default: begin
               phase_in = PhCode;
            end
         endcase
      end

      result.done_res   = final_byte;
      result.status     = error_status_in;
      result.total_size = (error_status_in == tlvf_pkg::StOk) ? matched_total_in : 17'd0;
   end

   // Hold parser state; the final byte of a buffer returns it to the start
   always_ff @(posedge clock) begin
      if (reset || (advance && final_byte)) begin
         phase_ff           <= PhCode;
         value_remaining_ff <= 7'd0;
         record_matches_ff  <= 1'b0;
         matched_total_ff   <= 17'd0;
         error_status_ff    <= tlvf_pkg::StOk;
         pending_code_ff    <= 7'd0;
      end else if (advance) begin
         phase_ff           <= phase_in;
         value_remaining_ff <= value_remaining_in;
         record_matches_ff  <= record_matches_in;
         matched_total_ff   <= matched_total_in;
         error_status_ff    <= error_status_in;
         pending_code_ff    <= pending_code_in;
      end
   end

endmodule

FILE: rtl/tlv_record_filter_unit.sv
// Type-length-value record filter. Each request carries one buffer byte and
// the count of buffer bytes still to come (including it); each request gives
// exactly one response with the extracted value byte (flagged in tuser), the
// error status and the running total of matching record sizes, with tlast on
// the final byte of the buffer. One request is taken every clock cycle while
// the response is not stalled; an accepted request moves from the input register
// through one parse pass into the response register when it has room, and the
// parser state is updated in that same single pass. A stalled response does
// not stop one further request from being taken into the input register.
module tlv_record_filter_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] data_byte, [24:8] bytes_left, [31:25] zero
   input  logic [tlvf_pkg::ReqDataWidth-1:0] req_tdata,
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] value_byte, [10:8] status, [27:11] total_size, [31:28] zero
   output logic [tlvf_pkg::RspDataWidth-1:0] rsp_tdata,
   // [0] value_valid
   output logic                              rsp_tuser,
   // done_res
   output logic                              rsp_tlast,
   // code_of_interest register
   input  logic                              csr_wr_en,
   input  logic [6:0]                        csr_wr_data
);

   logic                 in_valid_ff, in_valid_in;
   tlvf_pkg::item_type   in_item_ff;
   logic                 out_valid_ff, out_valid_in;
   tlvf_pkg::result_type out_res_ff;
   tlvf_pkg::result_type parse_res;
   logic [6:0]           code_ff;
   logic                 advance;
   logic                 req_take;

   // Move the held request into the response register when it has room
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= 7'd0;
      end else if (csr_wr_en) begin
         code_ff <= csr_wr_data;
      end
   end

   // Input and response valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture request and response payloads
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.data_byte  <= req_tdata[7:0];
         in_item_ff.bytes_left <= req_tdata[24:8];
      end
      if (advance) begin
         out_res_ff <= parse_res;
      end
   end

   tlvf_parse_core u_core (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .item             (in_item_ff),
      .code_of_interest (code_ff),
      .result           (parse_res)
   );

   // Pack the response
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.value_valid;
   assign rsp_tlast  = out_res_ff.done_res;
   assign rsp_tdata  = {4'b0, out_res_ff.total_size, out_res_ff.status,
                        out_res_ff.value_byte};

`ifndef SYNTHESIS
   // Hold a stalled response steady until it is taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable({rsp_tuser, rsp_tlast, rsp_tdata}))
      else $error("stalled response changed");

   // An errored response never reports a running total
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[10:8] != tlvf_pkg::StOk) |-> rsp_tdata[27:11] == 17'd0)
      else $error("total reported alongside an error status");

   // A new request never lands on a held request that has not moved on
   assert property (@(posedge clock) disable iff (reset)
      req_take && in_valid_ff |-> advance)
      else $error("held request overwritten");

   // Nothing is offered straight after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !in_valid_ff)
      else $error("valid state survived reset");
`endif

endmodule
